// File: rtl/text_terminal_cursor_engine_core_assert.svh
// ----------------------------------------------------------------------------
// text terminal assertion macros
// shared assertion forms for the terminal checker
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_CORE_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define TTCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terminal assertion failed");

// next-cycle implication
`define TTCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terminal assertion failed");

`endif

// File: rtl/ttce_pkg.sv
// ----------------------------------------------------------------------------
// ttce_pkg
// types and constants of the text terminal cursor engine
// ----------------------------------------------------------------------------
package ttce_pkg;

    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int CHR_W = 7;

    localparam logic [CHR_W-1:0] CH_LF = 7'd10;
    localparam logic [CHR_W-1:0] CH_CR = 7'd13;
    localparam logic [CHR_W-1:0] CH_BS = 7'd8;
    localparam logic [CHR_W-1:0] CH_SP = 7'd32;

    localparam logic [1:0] CFG_CURSOR_VISIBLE = 2'd0;
    localparam logic [1:0] CFG_HAS_FOCUS      = 2'd1;

    typedef enum logic [1:0] {
        REQ_FEED     = 2'd0,
        REQ_TYPED_BS = 2'd1,
        REQ_CLEAR    = 2'd2,
        REQ_READ     = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STYLE_HIDDEN  = 2'd0,
        STYLE_NORMAL  = 2'd1,
        STYLE_FOCUSED = 2'd2
    } t_style;

    typedef struct packed {
        t_req_type          req_type;
        logic [CHR_W-1:0]   ch;
        logic [ROW_W-1:0]   read_row;
        logic [COL_W-1:0]   read_col;
    } t_req;

    typedef struct packed {
        logic               cell_written;
        logic [ROW_W-1:0]   cell_row;
        logic [COL_W-1:0]   cell_col;
        logic [CHR_W-1:0]   cell_char;
        logic [ROW_W-1:0]   cursor_row;
        logic [COL_W-1:0]   cursor_col;
        t_style             cursor_style;
        logic               full_redraw;
        logic [CHR_W-1:0]   read_char;
        logic               read_beyond_end;
    } t_res;

    // write enables of the two memories
    typedef struct packed {
        logic len;
        logic chr;
    } t_mem_we;

endpackage

// File: rtl/ttce_mem.sv
// ----------------------------------------------------------------------------
// ttce_mem
// character store and line length memories, registered reads
// ----------------------------------------------------------------------------
module ttce_mem
    import ttce_pkg::*;
#(
    parameter int COLS  = 80,
    parameter int LINES = 64
) (
    input  logic                                i_clk,
    input  t_mem_we                             i_we,
    input  logic [$clog2(LINES)-1:0]            i_len_raddr,
    output logic [COL_W-1:0]                    o_len_rdata,
    input  logic [$clog2(LINES)-1:0]            i_len_waddr,
    input  logic [COL_W-1:0]                    i_len_wdata,
    input  logic [$clog2(LINES*COLS)-1:0]       i_chr_raddr,
    output logic [CHR_W-1:0]                    o_chr_rdata,
    input  logic [$clog2(LINES*COLS)-1:0]       i_chr_waddr,
    input  logic [CHR_W-1:0]                    i_chr_wdata
);

    logic [COL_W-1:0] r_len_mem [LINES];
    logic [CHR_W-1:0] r_chr_mem [LINES*COLS];
    logic [COL_W-1:0] r_len_rd;
    logic [CHR_W-1:0] r_chr_rd;

    always_ff @(posedge i_clk) begin
        if (i_we.len) begin
            r_len_mem[i_len_waddr] <= i_len_wdata;
        end
        r_len_rd <= r_len_mem[i_len_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.chr) begin
            r_chr_mem[i_chr_waddr] <= i_chr_wdata;
        end
        r_chr_rd <= r_chr_mem[i_chr_raddr];
    end

    assign o_len_rdata = r_len_rd;
    assign o_chr_rdata = r_chr_rd;

endmodule

// File: rtl/ttce_ctrl.sv
// ----------------------------------------------------------------------------
// ttce_ctrl
// request sequencer: lookup, execute, cell store with space fill, clear sweep
// ----------------------------------------------------------------------------
module ttce_ctrl
    import ttce_pkg::*;
#(
    parameter int COLS  = 80,
    parameter int ROWS  = 30,
    parameter int LINES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  t_req                                i_req,
    input  t_style                              i_style,
    output logic                                o_done,
    output t_res                                o_res,
    output t_mem_we                             o_we,
    output logic [$clog2(LINES)-1:0]            o_len_raddr,
    input  logic [COL_W-1:0]                    i_len_rdata,
    output logic [$clog2(LINES)-1:0]            o_len_waddr,
    output logic [COL_W-1:0]                    o_len_wdata,
    output logic [$clog2(LINES*COLS)-1:0]       o_chr_raddr,
    input  logic [CHR_W-1:0]                    i_chr_rdata,
    output logic [$clog2(LINES*COLS)-1:0]       o_chr_waddr,
    output logic [CHR_W-1:0]                    o_chr_wdata
);

    localparam int LW = $clog2(LINES);
    localparam int AW = $clog2(LINES*COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_STORE,
        S_CLR
    } t_state;

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic [LW-1:0]      r_top, n_top;
    logic [ROW_W-1:0]   r_crow, n_crow;
    logic [COL_W-1:0]   r_ccol, n_ccol;
    logic [LW-1:0]      r_back, n_back;
    t_res               r_res, n_res;
    logic               r_done, n_done;
    logic [LW-1:0]      r_wline, n_wline;
    logic [COL_W-1:0]   r_wcol, n_wcol;
    logic [CHR_W-1:0]   r_wch, n_wch;
    logic [COL_W-1:0]   r_fcol, n_fcol;
    logic [COL_W-1:0]   r_wlen, n_wlen;
    logic [LW-1:0]      r_clr_idx, n_clr_idx;
    logic               r_clr_emit, n_clr_emit;

    logic [LW-1:0]      cur_line;
    logic [LW-1:0]      prev_line;
    logic [LW-1:0]      next_line;
    logic [LW-1:0]      rd_line;
    logic [COL_W-1:0]   rd_col;

    function automatic logic [LW-1:0] ring_line(input logic [LW-1:0] top,
                                                input logic [ROW_W-1:0] row);
        logic [LW:0] sum;
        sum = {1'b0, top} + {{(LW+1-ROW_W){1'b0}}, row};
        if (sum >= (LW+1)'(LINES)) begin
            sum = sum - (LW+1)'(LINES);
        end
        return sum[LW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] line,
                                                input logic [COL_W-1:0] col);
        return AW'(line) * AW'(COLS) + AW'(col);
    endfunction

    assign cur_line  = ring_line(r_top, r_crow);
    assign prev_line = (cur_line == '0) ? LW'(LINES-1) : cur_line - LW'(1);
    assign next_line = (cur_line == LW'(LINES-1)) ? '0 : cur_line + LW'(1);
    assign rd_line   = ring_line(r_top, r_req.read_row);
    // out-of-range columns read as space anyway, keep the address in bounds
    assign rd_col    = (r_req.read_col < COL_W'(COLS)) ? r_req.read_col : '0;

    always_comb begin
        logic               store_go;
        logic               newline;
        logic               zero_we;
        logic [LW-1:0]      zero_line;
        logic [COL_W:0]     col_inc;

        n_state    = r_state;
        n_req      = r_req;
        n_top      = r_top;
        n_crow     = r_crow;
        n_ccol     = r_ccol;
        n_back     = r_back;
        n_res      = r_res;
        n_done     = 1'b0;
        n_wline    = r_wline;
        n_wcol     = r_wcol;
        n_wch      = r_wch;
        n_fcol     = r_fcol;
        n_wlen     = r_wlen;
        n_clr_idx  = r_clr_idx;
        n_clr_emit = r_clr_emit;
        store_go   = 1'b0;
        newline    = 1'b0;
        zero_we    = 1'b0;
        zero_line  = cur_line;
        col_inc    = {1'b0, r_ccol} + (COL_W+1)'(1);

        o_we        = '0;
        o_len_raddr = cur_line;
        o_len_waddr = '0;
        o_len_wdata = '0;
        o_chr_raddr = cell_addr(rd_line, rd_col);
        o_chr_waddr = '0;
        o_chr_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                // typed backspace at column zero needs the line above
                if (r_req.req_type == REQ_READ) begin
                    o_len_raddr = rd_line;
                end else if (r_req.req_type == REQ_TYPED_BS && r_ccol == '0) begin
                    o_len_raddr = prev_line;
                end else begin
                    o_len_raddr = cur_line;
                end
                n_state = S_EXEC;
            end

            S_EXEC: begin
                n_res              = '0;
                n_state            = S_IDLE;
                n_wline            = cur_line;
                n_fcol             = i_len_rdata;
                n_wlen             = i_len_rdata;
                case (r_req.req_type)
                    REQ_FEED: begin
                        if (r_req.ch == CH_LF) begin
                            newline = 1'b1;
                        end else if (r_req.ch == CH_CR) begin
                            n_ccol = '0;
                        end else if (r_req.ch == CH_BS) begin
                            if (r_ccol != '0) begin
                                n_ccol   = r_ccol - COL_W'(1);
                                n_wcol   = r_ccol - COL_W'(1);
                                n_wch    = CH_SP;
                                store_go = 1'b1;
                                n_res.cell_row = r_crow;
                            end
                        end else begin
                            n_wcol   = r_ccol;
                            n_wch    = r_req.ch;
                            store_go = 1'b1;
                            n_res.cell_row = r_crow;
                            n_ccol   = col_inc[COL_W-1:0];
                            if (col_inc >= (COL_W+1)'(COLS)) begin
                                newline = 1'b1;
                            end
                        end
                    end
                    REQ_TYPED_BS: begin
                        if (r_ccol != '0) begin
                            n_ccol   = r_ccol - COL_W'(1);
                            n_wcol   = r_ccol - COL_W'(1);
                            n_wch    = CH_SP;
                            store_go = 1'b1;
                            n_res.cell_row = r_crow;
                        end else if (r_back != '0) begin
                            // drop this line, step back to the end of the one above
                            zero_we   = 1'b1;
                            zero_line = cur_line;
                            n_back    = r_back - LW'(1);
                            if (r_crow == '0) begin
                                n_top = (r_top == '0) ? LW'(LINES-1) : r_top - LW'(1);
                                n_res.full_redraw = 1'b1;
                            end else begin
                                n_crow = r_crow - ROW_W'(1);
                            end
                            n_ccol   = COL_W'(COLS-1);
                            n_wline  = prev_line;
                            n_wcol   = COL_W'(COLS-1);
                            n_wch    = CH_SP;
                            store_go = 1'b1;
                            n_res.cell_row = n_crow;
                        end
                    end
                    REQ_CLEAR: begin
                        n_top      = '0;
                        n_crow     = '0;
                        n_ccol     = '0;
                        n_back     = '0;
                        n_res.full_redraw = 1'b1;
                        n_clr_idx  = '0;
                        n_clr_emit = 1'b1;
                        n_state    = S_CLR;
                    end
                    REQ_READ: begin
                        if (r_req.read_row >= ROW_W'(ROWS) || r_req.read_row > r_crow) begin
                            n_res.read_beyond_end = 1'b1;
                            n_res.read_char       = CH_SP;
                        end else if (r_req.read_col < COL_W'(COLS)
                                     && r_req.read_col < i_len_rdata) begin
                            n_res.read_char = i_chr_rdata;
                        end else begin
                            n_res.read_char = CH_SP;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase

                if (newline) begin
                    n_ccol = '0;
                    if (r_back < LW'(LINES-1)) begin
                        n_back = r_back + LW'(1);
                    end
                    if ({1'b0, r_crow} + (ROW_W+1)'(1) >= (ROW_W+1)'(ROWS)) begin
                        n_top = (r_top == LW'(LINES-1)) ? '0 : r_top + LW'(1);
                        n_res.full_redraw = 1'b1;
                    end else begin
                        n_crow = r_crow + ROW_W'(1);
                    end
                    zero_we   = 1'b1;
                    zero_line = next_line;
                end

                o_we.len    = zero_we;
                o_len_waddr = zero_line;
                o_len_wdata = '0;

                if (store_go) begin
                    n_res.cell_written = 1'b1;
                    n_res.cell_col     = n_wcol;
                    n_res.cell_char    = n_wch;
                    n_state            = S_STORE;
                end else if (n_state == S_IDLE) begin
                    n_done = 1'b1;
                end
                n_res.cursor_row   = n_crow;
                n_res.cursor_col   = n_ccol;
                n_res.cursor_style = i_style;
            end

            S_STORE: begin
                // cells skipped past the old line end become spaces
                if (r_fcol < r_wcol) begin
                    o_we.chr    = 1'b1;
                    o_chr_waddr = cell_addr(r_wline, r_fcol);
                    o_chr_wdata = CH_SP;
                    n_fcol      = r_fcol + COL_W'(1);
                end else begin
                    o_we.chr    = 1'b1;
                    o_chr_waddr = cell_addr(r_wline, r_wcol);
                    o_chr_wdata = r_wch;
                    if ({1'b0, r_wcol} + (COL_W+1)'(1) > {1'b0, r_wlen}) begin
                        o_we.len    = 1'b1;
                        o_len_waddr = r_wline;
                        o_len_wdata = r_wcol + COL_W'(1);
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_CLR: begin
                o_we.len    = 1'b1;
                o_len_waddr = r_clr_idx;
                o_len_wdata = '0;
                if (r_clr_idx == LW'(LINES-1)) begin
                    n_done  = r_clr_emit;
                    n_state = S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + LW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_top      <= '0;
            r_crow     <= '0;
            r_ccol     <= '0;
            r_back     <= '0;
            r_done     <= 1'b0;
            r_clr_idx  <= '0;
            r_clr_emit <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_top      <= n_top;
            r_crow     <= n_crow;
            r_ccol     <= n_ccol;
            r_back     <= n_back;
            r_done     <= n_done;
            r_clr_idx  <= n_clr_idx;
            r_clr_emit <= n_clr_emit;
        end
        r_req   <= n_req;
        r_res   <= n_res;
        r_wline <= n_wline;
        r_wcol  <= n_wcol;
        r_wch   <= n_wch;
        r_fcol  <= n_fcol;
        r_wlen  <= n_wlen;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: rtl/text_terminal_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_core
// character terminal with a ring of history lines, a scroll top and a cursor
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------
//  request  | start, busy (taken: !busy)     | i_req   (t_req)
//  result   | o_done, one cycle, no stall    | o_res   (t_res)
//  config   | i_cfg_valid, o_cfg_ready       | i_cfg_index, i_cfg_data
//
//  an item is taken when start is high and busy is low; o_done pulses
//  after the lookup and execute states for LF, CR, read and no-op items
//  a cell store adds the store state, which first fills with spaces the
//  cells past the old line end (up to COLS-1 when a typed backspace steps
//  back onto a short line); clear sweeps the line length memory after the
//  execute state, and after reset the same sweep runs with busy high
//  the result strobe cannot be held off; config is taken every cycle
// ----------------------------------------------------------------------------
module text_terminal_cursor_engine_core
    import ttce_pkg::*;
#(
    parameter int COLS  = 80,
    parameter int ROWS  = 30,
    parameter int LINES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data
);

    localparam int LW = $clog2(LINES);
    localparam int AW = $clog2(LINES*COLS);

    logic               r_cursor_visible;
    logic               r_has_focus;
    t_style             style;

    t_mem_we            mem_we;
    logic [LW-1:0]      len_raddr;
    logic [COL_W-1:0]   len_rdata;
    logic [LW-1:0]      len_waddr;
    logic [COL_W-1:0]   len_wdata;
    logic [AW-1:0]      chr_raddr;
    logic [CHR_W-1:0]   chr_rdata;
    logic [AW-1:0]      chr_waddr;
    logic [CHR_W-1:0]   chr_wdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_visible <= 1'b1;
            r_has_focus      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_CURSOR_VISIBLE) begin
                r_cursor_visible <= i_cfg_data;
            end else if (i_cfg_index == CFG_HAS_FOCUS) begin
                r_has_focus <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (!r_cursor_visible) begin
            style = STYLE_HIDDEN;
        end else if (r_has_focus) begin
            style = STYLE_FOCUSED;
        end else begin
            style = STYLE_NORMAL;
        end
    end

    ttce_ctrl #(
        .COLS  (COLS),
        .ROWS  (ROWS),
        .LINES (LINES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (i_req),
        .i_style     (style),
        .o_done      (o_done),
        .o_res       (o_res),
        .o_we        (mem_we),
        .o_len_raddr (len_raddr),
        .i_len_rdata (len_rdata),
        .o_len_waddr (len_waddr),
        .o_len_wdata (len_wdata),
        .o_chr_raddr (chr_raddr),
        .i_chr_rdata (chr_rdata),
        .o_chr_waddr (chr_waddr),
        .o_chr_wdata (chr_wdata)
    );

    ttce_mem #(
        .COLS  (COLS),
        .LINES (LINES)
    ) u_mem (
        .i_clk       (i_clk),
        .i_we        (mem_we),
        .i_len_raddr (len_raddr),
        .o_len_rdata (len_rdata),
        .i_len_waddr (len_waddr),
        .i_len_wdata (len_wdata),
        .i_chr_raddr (chr_raddr),
        .o_chr_rdata (chr_rdata),
        .i_chr_waddr (chr_waddr),
        .i_chr_wdata (chr_wdata)
    );

endmodule

// File: rtl/ttce_checker.sv
// ----------------------------------------------------------------------------
// ttce_checker
// port-level checks of the text terminal, bound to the top level
// ----------------------------------------------------------------------------
`include "text_terminal_cursor_engine_core_assert.svh"

module ttce_checker
    import ttce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    busy,
    input  logic    o_done,
    input  t_res    o_res
);

    // an accepted item keeps the engine busy in the next cycle
    `TTCE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)

    // a result only follows a cycle of work
    `TTCE_ASSERT_IMP(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy))

    // no cell fields without a write
    `TTCE_ASSERT_IMP(a_quiet_cell, i_clk, i_rst_n, o_done && !o_res.cell_written, (o_res.cell_row == '0) && (o_res.cell_col == '0) && (o_res.cell_char == '0))

    // a read below the last line always yields a space
    `TTCE_ASSERT_IMP(a_beyond_space, i_clk, i_rst_n, o_done && o_res.read_beyond_end, o_res.read_char == CH_SP)

endmodule

bind text_terminal_cursor_engine_core ttce_checker u_ttce_checker (.*);

// File: bench/tb_text_terminal_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// tb_text_terminal_cursor_engine_core
// self-checking bench for the text terminal cursor engine: a shadow terminal
// predicts every result from the items taken, and each o_done strobe is
// compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_text_terminal_cursor_engine_core;
    import ttce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = 80;
    localparam int ROWS  = 30;
    localparam int LINES = 64;

    // index that the block has no register for
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_req       i_req       = '0;
    logic       o_done;
    t_res       o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_CURSOR_VISIBLE;
    logic       i_cfg_data  = 1'b0;

    text_terminal_cursor_engine_core #(
        .COLS  (COLS),
        .ROWS  (ROWS),
        .LINES (LINES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow terminal
    logic [CHR_W-1:0] shadow_chars [LINES*COLS];
    logic [COL_W-1:0] shadow_len [LINES];
    int               top_ln;
    int               cur_row;
    int               cur_col;
    int               back_cnt;
    logic             vis_cfg;
    logic             foc_cfg;

    t_res             due_results [$];
    int               mismatches;

    function automatic void reset_shadow();
        foreach (shadow_chars[k]) shadow_chars[k] = '0;
        foreach (shadow_len[k]) shadow_len[k] = '0;
        top_ln   = 0;
        cur_row  = 0;
        cur_col  = 0;
        back_cnt = 0;
        vis_cfg  = 1'b1;
        foc_cfg  = 1'b0;
    endfunction

    function automatic int ring_of(int row);
        return (top_ln + row) % LINES;
    endfunction

    // every store lands at the cursor; gap past the line end is space filled
    function automatic void write_at_cursor(inout t_res r, input logic [CHR_W-1:0] c);
        int ln;
        int len;
        ln  = ring_of(cur_row);
        len = shadow_len[ln];
        for (int k = len; k < cur_col; k++) shadow_chars[ln*COLS + k] = CH_SP;
        shadow_chars[ln*COLS + cur_col] = c;
        if (cur_col + 1 > len) shadow_len[ln] = COL_W'(cur_col + 1);
        r.cell_written = 1'b1;
        r.cell_row     = ROW_W'(cur_row);
        r.cell_col     = COL_W'(cur_col);
        r.cell_char    = c;
    endfunction

    function automatic logic next_line();
        logic scrolled;
        scrolled = 1'b0;
        cur_col  = 0;
        if (back_cnt < LINES - 1) back_cnt++;
        if (cur_row + 1 >= ROWS) begin
            top_ln   = (top_ln + 1) % LINES;
            scrolled = 1'b1;
        end else begin
            cur_row++;
        end
        shadow_len[ring_of(cur_row)] = '0;
        return scrolled;
    endfunction

    function automatic t_res terminal_step(t_req rq);
        t_res r;
        int   ln;
        r = '0;
        case (rq.req_type)
            REQ_FEED: begin
                if (rq.ch == CH_LF) begin
                    r.full_redraw = next_line();
                end else if (rq.ch == CH_CR) begin
                    cur_col = 0;
                end else if (rq.ch == CH_BS) begin
                    if (cur_col != 0) begin
                        cur_col--;
                        write_at_cursor(r, CH_SP);
                    end
                end else begin
                    write_at_cursor(r, rq.ch);
                    cur_col++;
                    if (cur_col >= COLS) r.full_redraw = next_line();
                end
            end
            REQ_TYPED_BS: begin
                if (cur_col != 0) begin
                    cur_col--;
                    write_at_cursor(r, CH_SP);
                end else if (back_cnt != 0) begin
                    // drop the line and step back onto the previous one
                    shadow_len[ring_of(cur_row)] = '0;
                    back_cnt--;
                    if (cur_row == 0) begin
                        top_ln        = (top_ln + LINES - 1) % LINES;
                        r.full_redraw = 1'b1;
                    end else begin
                        cur_row--;
                    end
                    cur_col = COLS - 1;
                    write_at_cursor(r, CH_SP);
                end
            end
            REQ_CLEAR: begin
                foreach (shadow_len[k]) shadow_len[k] = '0;
                top_ln        = 0;
                cur_row       = 0;
                cur_col       = 0;
                back_cnt      = 0;
                r.full_redraw = 1'b1;
            end
            default: begin
                if (rq.read_row >= ROWS || rq.read_row > cur_row) begin
                    r.read_beyond_end = 1'b1;
                    r.read_char       = CH_SP;
                end else begin
                    ln = ring_of(rq.read_row);
                    if (rq.read_col < COLS && rq.read_col < shadow_len[ln])
                        r.read_char = shadow_chars[ln*COLS + rq.read_col];
                    else
                        r.read_char = CH_SP;
                end
            end
        endcase
        r.cursor_row   = ROW_W'(cur_row);
        r.cursor_col   = COL_W'(cur_col);
        r.cursor_style = !vis_cfg ? STYLE_HIDDEN : (foc_cfg ? STYLE_FOCUSED : STYLE_NORMAL);
        return r;
    endfunction

    // result checking
    task automatic check_field(input string nm, input logic [6:0] want,
                               input logic [6:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0t %s expected %0d actual %0d", $time, nm, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done === 1'b1) begin
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result, expected none actual %h", $time, o_res);
            end else begin
                want = due_results.pop_front();
                check_field("cell_written", 7'(want.cell_written), 7'(o_res.cell_written));
                check_field("cell_row", 7'(want.cell_row), 7'(o_res.cell_row));
                check_field("cell_col", 7'(want.cell_col), 7'(o_res.cell_col));
                check_field("cell_char", 7'(want.cell_char), 7'(o_res.cell_char));
                check_field("cursor_row", 7'(want.cursor_row), 7'(o_res.cursor_row));
                check_field("cursor_col", 7'(want.cursor_col), 7'(o_res.cursor_col));
                check_field("cursor_style", 7'(want.cursor_style), 7'(o_res.cursor_style));
                check_field("full_redraw", 7'(want.full_redraw), 7'(o_res.full_redraw));
                check_field("read_char", 7'(want.read_char), 7'(o_res.read_char));
                check_field("read_beyond_end", 7'(want.read_beyond_end),
                            7'(o_res.read_beyond_end));
            end
        end
    end

    // stimulus helpers
    // start is left high after an item is taken so the next one can follow
    task automatic send_req(input t_req rq);
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy !== 1'b0);
        due_results.insert(due_results.size(), terminal_step(rq));
    endtask

    task automatic hold_off(input int pct);
        if ($urandom_range(99, 0) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0 || busy !== 1'b0);
    endtask

    task automatic apply_cfg(input logic vis, input logic foc);
        logic [1:0] idx [3];
        logic       val [3];
        idx = '{CFG_CURSOR_VISIBLE, CFG_HAS_FOCUS, CFG_SPARE};
        val = '{vis, foc, 1'($urandom_range(1, 0))};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            case (idx[k])
                CFG_CURSOR_VISIBLE: vis_cfg = val[k];
                CFG_HAS_FOCUS:      foc_cfg = val[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req mk_req(t_req_type t, logic [CHR_W-1:0] c,
                                    logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        t_req rq;
        rq.req_type = t;
        rq.ch       = c;
        rq.read_row = row;
        rq.read_col = col;
        return rq;
    endfunction

    // weights are percentages; whatever is left feeds a random character
    function automatic t_req pick_item(int p_lf, int p_cr, int p_fbs, int p_typed,
                                       int p_clr, int p_read);
        t_req rq;
        int   roll;
        int   row;
        rq.req_type = REQ_FEED;
        rq.ch       = CHR_W'($urandom_range(127, 0));
        rq.read_row = ROW_W'($urandom_range(31, 0));
        rq.read_col = COL_W'($urandom_range(127, 0));
        roll = $urandom_range(99, 0);
        if (roll < p_lf) begin
            rq.ch = CH_LF;
        end else if (roll < p_lf + p_cr) begin
            rq.ch = CH_CR;
        end else if (roll < p_lf + p_cr + p_fbs) begin
            rq.ch = CH_BS;
        end else if (roll < p_lf + p_cr + p_fbs + p_typed) begin
            rq.req_type = REQ_TYPED_BS;
        end else if (roll < p_lf + p_cr + p_fbs + p_typed + p_clr) begin
            rq.req_type = REQ_CLEAR;
        end else if (roll < p_lf + p_cr + p_fbs + p_typed + p_clr + p_read) begin
            rq.req_type = REQ_READ;
            // mostly aim at existing text, the rest anywhere
            if ($urandom_range(3, 0) != 0) begin
                row         = $urandom_range(cur_row, 0);
                rq.read_row = ROW_W'(row);
                rq.read_col = COL_W'($urandom_range(int'(shadow_len[ring_of(row)]) + 1, 0));
            end
        end
        return rq;
    endfunction

    task automatic run_random(int count, int idle_pct, int p_lf, int p_cr, int p_fbs,
                              int p_typed, int p_clr, int p_read);
        for (int n = 0; n < count; n++) begin
            hold_off(idle_pct);
            send_req(pick_item(p_lf, p_cr, p_fbs, p_typed, p_clr, p_read));
        end
    endtask

    // tests
    task automatic test_directed();
        t_req items [$];
        settle();
        apply_cfg(1'b1, 1'b0);
        items = '{
            mk_req(REQ_READ, 7'd0, 5'd0, 7'd0),
            mk_req(REQ_TYPED_BS, 7'd0, 5'd0, 7'd0),     // nothing to drop
            mk_req(REQ_FEED, CH_BS, 5'd31, 7'd127),     // fed BS at column 0
            mk_req(REQ_FEED, 7'd65, 5'd0, 7'd0),
            mk_req(REQ_FEED, 7'd0, 5'd0, 7'd0),
            mk_req(REQ_FEED, 7'd127, 5'd31, 7'd127),
            mk_req(REQ_FEED, 7'd7, 5'd0, 7'd0),         // control code stored as is
            mk_req(REQ_FEED, CH_BS, 5'd0, 7'd0),
            mk_req(REQ_TYPED_BS, 7'd127, 5'd0, 7'd0),
            mk_req(REQ_FEED, CH_CR, 5'd0, 7'd0),
            mk_req(REQ_READ, 7'd0, 5'd0, 7'd0),
            mk_req(REQ_READ, 7'd0, 5'd0, 7'd79),
            mk_req(REQ_READ, 7'd0, 5'd31, 7'd0),        // row past the screen
            mk_req(REQ_READ, 7'd0, 5'd0, 7'd127),       // column past the screen
            mk_req(REQ_FEED, CH_LF, 5'd0, 7'd0),
            mk_req(REQ_READ, 7'd0, 5'd1, 7'd0),
            mk_req(REQ_READ, 7'd0, 5'd5, 7'd3),
            mk_req(REQ_TYPED_BS, 7'd0, 5'd0, 7'd0),     // back onto a short line
            mk_req(REQ_READ, 7'd0, 5'd0, 7'd40),
            mk_req(REQ_READ, 7'd0, 5'd0, 7'd1),
            mk_req(REQ_FEED, 7'd122, 5'd0, 7'd0),       // last column, wraps
            mk_req(REQ_CLEAR, 7'd0, 5'd0, 7'd0),
            mk_req(REQ_READ, 7'd0, 5'd0, 7'd0),
            mk_req(REQ_FEED, CH_LF, 5'd0, 7'd0)
        };
        foreach (items[k]) begin
            hold_off(30);
            send_req(items[k]);
        end
    endtask

    task automatic test_text_fill();
        settle();
        apply_cfg(1'b1, 1'b1);
        run_random(500, 30, 4, 3, 5, 4, 1, 20);
    endtask

    // many new lines: scrolling and reuse of the oldest history lines
    task automatic test_scroll_history();
        settle();
        apply_cfg(1'b0, 1'b0);
        run_random(450, 15, 25, 3, 3, 2, 0, 17);
    endtask

    // return then typed backspace walks up the history, scrolling back at row 0
    task automatic test_step_back();
        settle();
        apply_cfg(1'b1, 1'b0);
        run_random(350, 25, 3, 25, 2, 35, 0, 20);
    endtask

    task automatic test_back_to_back();
        settle();
        apply_cfg(1'b0, 1'b1);
        run_random(300, 0, 8, 5, 4, 8, 1, 20);
    endtask

    initial begin
        mismatches = 0;
        reset_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_text_fill();
        test_scroll_history();
        test_step_back();
        test_back_to_back();
        settle();
        repeat (LINES + COLS) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: text_terminal_cursor_engine_core.f
+incdir+rtl
rtl/ttce_pkg.sv
rtl/ttce_mem.sv
rtl/ttce_ctrl.sv
rtl/text_terminal_cursor_engine_core.sv
rtl/ttce_checker.sv
bench/tb_text_terminal_cursor_engine_core.sv
